>>> rtl/core/tssp_pkg.sv
`default_nettype none

package tssp_pkg;

    // Pool geometry and animation timing.
    localparam int SLOTS              = 128;
    localparam int PATTERN_COUNT      = 16;
    localparam int PATTERNS_PER_ROW   = 4;
    localparam int FRAMES_PER_PATTERN = 1;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int PAT_W     = 5;
    localparam int FRAME_W   = 16;
    localparam int POS_W     = 16;
    localparam int SLOT_ID_W = 7;
    localparam int TILE_W    = 10;
    localparam int TILE_MAX  = 1023;
    localparam int TSIZE_W   = 8;
    localparam int TPROD_W   = TSIZE_W + PAT_W;

    // A slot expires once its age reaches this many frames.
    localparam int AGE_LIMIT = PATTERN_COUNT * FRAMES_PER_PATTERN;

    // Age divided by frames per pattern through a reciprocal multiply.
    // Ages below the limit fit in AGE_W bits, and the shift keeps the
    // quotient exact for every such age.
    localparam int AGE_W       = 10;
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 18;
    localparam int RECIP       = (2 ** RECIP_SHIFT + FRAMES_PER_PATTERN - 1)
                                 / FRAMES_PER_PATTERN;
    localparam int PROD_W      = AGE_W + RECIP_W;

    localparam logic [PAT_W-1:0] PAT_EXPIRED = 5'd31;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 1'b1;

    localparam logic [TSIZE_W-1:0] TILE_SIZE_RESET = 8'd32;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SLOT_ID_W-1:0]    slot;
    } req_t;

    typedef struct packed {
        logic [SLOT_ID_W-1:0]    slot_used;
        logic                    status;
        logic                    active;
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic [TILE_W-1:0]       tile_x;
        logic [TILE_W-1:0]       tile_y;
    } rsp_t;

    // Row of a pattern in the sprite sheet: counts the row boundaries
    // that lie at or below the pattern number.
    function automatic logic [PAT_W-1:0] pat_row(input logic [PAT_W-1:0] p);
        logic [PAT_W-1:0] r;
        r = '0;
        for (int k = 1; k < (1 << PAT_W); k++)
        begin
            if (int'(p) >= k * PATTERNS_PER_ROW)
            begin
                r = r + 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/timed_sprite_slot_pool_unit.sv
// Pool of animated effect slots.
// Requests arrive on req (req_valid / req_stall) and each gives exactly one
// response on rsp (rsp_valid / rsp_stall). Tile size registers are written
// on the cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data); the user
// must write them only while the pool is idle, which the block does not
// enforce. cfg_ready is always high. A tick walks every slot once through
// one shared age unit: one slot read per cycle from the stamp memory, with
// the age divide and the pattern write in the cycle after each read.
// A create scans the live bits one slot per cycle for the lowest free slot.
// A query reads the slot memories, splits the pattern into row and column,
// then multiplies by the tile size.
// One request is handled at a time; req_stall is high from acceptance until
// its response is loaded into the output register. The next request is
// taken while that response still waits on a stalled receiver, and its own
// response is held until the output register empties.
// Reset clears all live bits, the frame counter and the response valid, and
// sets both tile sizes to 32; position, stamp and pattern memories are not
// cleared and are used only for live slots.
`default_nettype none

module timed_sprite_slot_pool_unit (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               req_valid,
    output logic                              req_stall,
    input  wire tssp_pkg::req_t               req,
    output logic                              rsp_valid,
    input  wire                               rsp_stall,
    output tssp_pkg::rsp_t                    rsp,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [tssp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [tssp_pkg::TSIZE_W-1:0]       cfg_data
);
    import tssp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK   = 3'd1;
    localparam logic [2:0] S_FIND   = 3'd2;
    localparam logic [2:0] S_QRD    = 3'd3;
    localparam logic [2:0] S_QSPLIT = 3'd4;
    localparam logic [2:0] S_QMUL   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [SLOTS-1:0]    live_reg, live_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [TSIZE_W-1:0]  tile_w_reg, tile_h_reg;
    logic                p1_valid_reg, p1_valid_next;
    logic [SLOT_W-1:0]   p1_idx_reg, p1_idx_next;
    logic                hit_reg, hit_next;
    logic [PAT_W-1:0]    row_reg, row_next;
    logic [PAT_W-1:0]    col_reg, col_next;
    req_t                req_reg, req_next;
    rsp_t                pend_reg, pend_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // Slot memories.
    logic signed [POS_W-1:0] x_mem [SLOTS];
    logic signed [POS_W-1:0] y_mem [SLOTS];
    logic [FRAME_W-1:0]      stamp_mem [SLOTS];
    logic [PAT_W-1:0]        pat_mem [SLOTS];

    logic signed [POS_W-1:0] x_rd_reg, y_rd_reg;
    logic [FRAME_W-1:0]      stamp_rd_reg;
    logic [PAT_W-1:0]        pat_rd_reg;

    logic [SLOT_W-1:0]       rd_addr;
    logic                    pos_we;
    logic [SLOT_W-1:0]       pos_waddr;
    logic                    pat_we;
    logic [SLOT_W-1:0]       pat_waddr;
    logic [PAT_W-1:0]        pat_wdata;

    // Shared age unit signals.
    logic [FRAME_W-1:0]      age;
    logic                    expired;
    logic [PROD_W-1:0]       age_prod;
    logic [PAT_W-1:0]        age_pat;

    logic [SLOT_W-1:0]       idx_slot;
    logic [SLOT_W-1:0]       q_slot;
    logic                    q_in_range;
    logic [TPROD_W-1:0]      tx_full, ty_full;
    logic                    req_fire;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign idx_slot   = idx_reg[SLOT_W-1:0];
    assign q_slot     = SLOT_W'(req_reg.slot);
    assign q_in_range = (int'(req_reg.slot) < SLOTS);

    assign age      = frame_reg - stamp_rd_reg;
    assign expired  = (int'(age) >= AGE_LIMIT);
    assign age_prod = PROD_W'(age[AGE_W-1:0]) * PROD_W'(RECIP);
    assign age_pat  = age_prod[RECIP_SHIFT +: PAT_W];

    assign tx_full = TPROD_W'(tile_w_reg) * TPROD_W'(col_reg);
    assign ty_full = TPROD_W'(tile_h_reg) * TPROD_W'(row_reg);

    assign rd_addr = (state_reg == S_TICK) ? idx_slot : q_slot;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        live_next      = live_reg;
        frame_next     = frame_reg;
        p1_valid_next  = 1'b0;
        p1_idx_next    = p1_idx_reg;
        hit_next       = hit_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        req_next       = req_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        pos_we         = 1'b0;
        pos_waddr      = idx_slot;
        pat_we         = 1'b0;
        pat_waddr      = idx_slot;
        pat_wdata      = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    req_next  = req;
                    idx_next  = '0;
                    pend_next = '0;
                    unique case (req.op)
                        OP_TICK:   state_next = S_TICK;
                        OP_CREATE: state_next = S_FIND;
                        OP_QUERY:  state_next = S_QRD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end

            S_TICK:
            begin
                // Second stage: the stamp read in the previous cycle is aged here.
                if (p1_valid_reg)
                begin
                    pat_we    = 1'b1;
                    pat_waddr = p1_idx_reg;
                    if (expired)
                    begin
                        pat_wdata              = PAT_EXPIRED;
                        live_next[p1_idx_reg]  = 1'b0;
                    end
                    else
                    begin
                        pat_wdata = age_pat;
                    end
                end
                if (idx_reg < CNT_W'(SLOTS))
                begin
                    p1_valid_next = live_reg[idx_slot];
                    p1_idx_next   = idx_slot;
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    frame_next = frame_reg + 1'b1;
                    state_next = S_DONE;
                end
            end

            S_FIND:
            begin
                if (idx_reg >= CNT_W'(SLOTS))
                begin
                    pend_next.status = STATUS_FULL;
                    state_next       = S_DONE;
                end
                else if (!live_reg[idx_slot])
                begin
                    pos_we              = 1'b1;
                    pat_we              = 1'b1;
                    pat_wdata           = '0;
                    live_next[idx_slot] = 1'b1;
                    pend_next.slot_used = SLOT_ID_W'(idx_reg);
                    pend_next.status    = STATUS_OK;
                    state_next          = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_QRD:
            begin
                hit_next   = q_in_range && live_reg[q_slot];
                state_next = S_QSPLIT;
            end

            S_QSPLIT:
            begin
                row_next   = pat_row(pat_rd_reg);
                col_next   = pat_rd_reg - PAT_W'(int'(pat_row(pat_rd_reg)) * PATTERNS_PER_ROW);
                state_next = S_QMUL;
            end

            S_QMUL:
            begin
                pend_next.slot_used = req_reg.slot;
                if (hit_reg)
                begin
                    pend_next.active = 1'b1;
                    pend_next.out_x  = x_rd_reg;
                    pend_next.out_y  = y_rd_reg;
                    pend_next.tile_x = (int'(tx_full) > TILE_MAX) ? TILE_W'(TILE_MAX)
                                                                  : TILE_W'(tx_full);
                    pend_next.tile_y = (int'(ty_full) > TILE_MAX) ? TILE_W'(TILE_MAX)
                                                                  : TILE_W'(ty_full);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            live_reg      <= '0;
            frame_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            tile_w_reg    <= TILE_SIZE_RESET;
            tile_h_reg    <= TILE_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            live_reg      <= live_next;
            frame_reg     <= frame_next;
            p1_valid_reg  <= p1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_TILE_WIDTH:  tile_w_reg <= cfg_data;
                    CFG_TILE_HEIGHT: tile_h_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= p1_idx_next;
        hit_reg    <= hit_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        req_reg    <= req_next;
        pend_reg   <= pend_next;
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            x_mem[pos_waddr]     <= req_reg.pos_x;
            y_mem[pos_waddr]     <= req_reg.pos_y;
            stamp_mem[pos_waddr] <= frame_reg;
        end
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= pat_wdata;
        end
        x_rd_reg     <= x_mem[rd_addr];
        y_rd_reg     <= y_mem[rd_addr];
        stamp_rd_reg <= stamp_mem[rd_addr];
        pat_rd_reg   <= pat_mem[rd_addr];
    end

`ifndef SYNTHESIS
    // An accepted request keeps the pool busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> req_stall)
        else $error("pool took a request but was not busy afterward");

    // The frame counter only moves at the end of a tick walk.
    a_frame_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_reg != $past(frame_reg)) |-> ($past(state_reg) == S_TICK))
        else $error("frame counter moved outside a tick");

    // The walk index never runs past the pool.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND || state_reg == S_TICK) |-> (idx_reg <= CNT_W'(SLOTS)))
        else $error("slot walk index beyond the pool");

    // A full response carries no slot and no live flag.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == STATUS_FULL)
            |-> (rsp_reg.slot_used == '0 && !rsp_reg.active))
        else $error("pool full response carries slot data");

    // A successful create leaves its slot live.
    a_create_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND && idx_reg < CNT_W'(SLOTS) && !live_reg[idx_slot])
            |=> live_reg[$past(idx_slot)])
        else $error("created slot not marked live");
`endif

endmodule

`default_nettype wire

>>> tb/tssp_pool_checker.sv
`default_nettype none

module tssp_pool_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             req_valid,
    input  wire                             req_stall,
    input  wire tssp_pkg::req_t             req,
    input  wire                             rsp_valid,
    input  wire                             rsp_stall,
    input  wire tssp_pkg::rsp_t             rsp,
    input  wire                             cfg_valid,
    input  wire                             cfg_ready,
    input  wire [tssp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [tssp_pkg::TSIZE_W-1:0]     cfg_data,
    output int                              rsp_owed,
    output int                              mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import tssp_pkg::*;

    // Shadow copy of the pool.
    logic                    slot_live [SLOTS];
    logic signed [POS_W-1:0] slot_x    [SLOTS];
    logic signed [POS_W-1:0] slot_y    [SLOTS];
    logic [FRAME_W-1:0]      slot_born [SLOTS];
    logic [PAT_W-1:0]        slot_pat  [SLOTS];
    logic [FRAME_W-1:0]      frame_now;
    logic [TSIZE_W-1:0]      tile_w;
    logic [TSIZE_W-1:0]      tile_h;

    rsp_t rsp_due [$];
    rsp_t want;
    int   fail_tally = 0;

    function automatic void advance_frame();
        logic [FRAME_W-1:0] age;
        int unsigned        step;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (slot_live[s])
            begin
                age  = frame_now - slot_born[s];
                step = int'(age) / FRAMES_PER_PATTERN;
                if (step >= PATTERN_COUNT)
                begin
                    slot_live[s] = 1'b0;
                    slot_pat[s]  = PAT_EXPIRED;
                end
                else
                begin
                    slot_pat[s] = step[PAT_W-1:0];
                end
            end
        end
        frame_now = frame_now + 1'b1;
    endfunction

    function automatic int clip_tile(input int v);
        return (v > TILE_MAX) ? TILE_MAX : v;
    endfunction

    function automatic rsp_t pool_answer(input req_t r);
        rsp_t        a;
        int          free_slot;
        int unsigned pat;
        a = '0;
        case (r.op)
            OP_TICK:
            begin
                advance_frame();
            end
            OP_CREATE:
            begin
                free_slot = -1;
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!slot_live[s] && free_slot < 0)
                    begin
                        free_slot = s;
                    end
                end
                if (free_slot >= 0)
                begin
                    slot_x[free_slot]    = r.pos_x;
                    slot_y[free_slot]    = r.pos_y;
                    slot_born[free_slot] = frame_now;
                    slot_pat[free_slot]  = '0;
                    slot_live[free_slot] = 1'b1;
                    a.slot_used = free_slot[SLOT_ID_W-1:0];
                    a.status    = STATUS_OK;
                end
                else
                begin
                    a.status = STATUS_FULL;
                end
            end
            OP_QUERY:
            begin
                a.slot_used = r.slot;
                if (int'(r.slot) < SLOTS && slot_live[r.slot])
                begin
                    pat      = int'(slot_pat[r.slot]);
                    a.active = 1'b1;
                    a.out_x  = slot_x[r.slot];
                    a.out_y  = slot_y[r.slot];
                    a.tile_x = TILE_W'(clip_tile(int'(tile_w) * (pat % PATTERNS_PER_ROW)));
                    a.tile_y = TILE_W'(clip_tile(int'(tile_h) * (pat / PATTERNS_PER_ROW)));
                end
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    function automatic void compare_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
            fail_tally++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_live[s] = 1'b0;
                slot_x[s]    = '0;
                slot_y[s]    = '0;
                slot_born[s] = '0;
                slot_pat[s]  = '0;
            end
            frame_now = '0;
            tile_w    = TILE_SIZE_RESET;
            tile_h    = TILE_SIZE_RESET;
            rsp_due.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response with no request outstanding: slot_used %0d",
                           rsp.slot_used);
                    fail_tally++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    compare_field("slot_used", int'(want.slot_used), int'(rsp.slot_used));
                    compare_field("status", int'(want.status), int'(rsp.status));
                    compare_field("active", int'(want.active), int'(rsp.active));
                    compare_field("out_x", int'(want.out_x), int'(rsp.out_x));
                    compare_field("out_y", int'(want.out_y), int'(rsp.out_y));
                    compare_field("tile_x", int'(want.tile_x), int'(rsp.tile_x));
                    compare_field("tile_y", int'(want.tile_y), int'(rsp.tile_y));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TILE_WIDTH)
                begin
                    tile_w = cfg_data;
                end
                else if (cfg_index == CFG_TILE_HEIGHT)
                begin
                    tile_h = cfg_data;
                end
            end
            if (req_valid && !req_stall)
            begin
                rsp_due.push_back(pool_answer(req));
            end
        end
        rsp_owed   <= rsp_due.size();
        mismatches <= fail_tally;
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tssp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int HOLD_CYCLES     = 1500;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 300;
    localparam int STALL_LIMIT     = 20000;

    typedef enum int {BURST_FILL, BURST_MIXED, BURST_AGE, BURST_NOISE} burst_kind_e;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    rsp_t                 rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TSIZE_W-1:0]   cfg_data;

    int rsp_owed;
    int mismatches;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_done     = 0;
    int quiet_cycles   = 0;

    // Tile sizes per phase, the extremes and a zero size among them.
    int unsigned phase_tw [PHASES] = '{1, 255, 0, 255, 7, 0, 128, 32};
    int unsigned phase_th [PHASES] = '{255, 1, 0, 255, 93, 200, 1, 32};

    timed_sprite_slot_pool_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tssp_pool_checker pool_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rsp_owed   (rsp_owed),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic req_t make_request(input logic [1:0] op, input int x, input int y,
                                          input int s);
        req_t r;
        r.op    = op;
        r.pos_x = x[POS_W-1:0];
        r.pos_y = y[POS_W-1:0];
        r.slot  = s[SLOT_ID_W-1:0];
        return r;
    endfunction

    function automatic req_t pick_request(input burst_kind_e kind);
        req_t        r;
        int unsigned roll;
        r.pos_x = POS_W'($urandom);
        r.pos_y = POS_W'($urandom);
        // Live slots crowd the low end of the pool, so aim queries there often.
        r.slot  = ($urandom_range(0, 1) == 0) ? SLOT_ID_W'($urandom_range(0, 15))
                                              : SLOT_ID_W'($urandom_range(0, 127));
        roll    = $urandom_range(0, 99);
        case (kind)
            BURST_FILL:
                r.op = (roll < 85) ? OP_CREATE : (roll < 97) ? OP_QUERY : OP_UNUSED;
            BURST_MIXED:
                r.op = (roll < 25) ? OP_TICK : (roll < 55) ? OP_CREATE :
                       (roll < 95) ? OP_QUERY : OP_UNUSED;
            BURST_AGE:
                r.op = (roll < 55) ? OP_TICK : (roll < 95) ? OP_QUERY : OP_CREATE;
            default:
                r.op = (roll < 50) ? OP_UNUSED : (roll < 80) ? OP_QUERY : OP_CREATE;
        endcase
        return r;
    endfunction

    task automatic send_request(input req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            req       <= pick_request(BURST_NOISE);
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (rsp_owed != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_tile_size(input int unsigned w, input int unsigned h);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TILE_WIDTH;
        cfg_data  <= w[TSIZE_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_index <= CFG_TILE_HEIGHT;
        cfg_data  <= h[TSIZE_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != holds_asked)
            begin
                hold_left  = HOLD_CYCLES;
                holds_done = holds_done + 1;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        burst_kind_e kind;
        int          len;
        int          sent;
        int unsigned roll;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TILE_WIDTH;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening with the reset tile size.
        send_request(make_request(OP_QUERY, 0, 0, 0));
        send_request(make_request(OP_QUERY, -1, -1, 127));
        send_request(make_request(OP_UNUSED, -1, -1, 127));
        send_request(make_request(OP_CREATE, -32768, 32767, 0));
        send_request(make_request(OP_CREATE, 32767, -32768, 127));
        send_request(make_request(OP_CREATE, 0, 0, 5));
        send_request(make_request(OP_CREATE, -1, -1, 0));
        send_request(make_request(OP_QUERY, 0, 0, 0));
        send_request(make_request(OP_QUERY, 0, 0, 1));
        send_request(make_request(OP_QUERY, 0, 0, 3));
        send_request(make_request(OP_TICK, -1, -1, 127));
        send_request(make_request(OP_QUERY, 0, 0, 0));
        repeat (5) send_request(make_request(OP_TICK, 0, 0, 0));
        send_request(make_request(OP_QUERY, 0, 0, 1));
        send_request(make_request(OP_UNUSED, 0, 0, 0));
        send_request(make_request(OP_CREATE, 16'h1234, 16'h8765, 0));
        send_request(make_request(OP_QUERY, 0, 0, 4));
        send_request(make_request(OP_QUERY, 0, 0, 5));
        send_request(make_request(OP_TICK, 0, 0, 0));
        send_request(make_request(OP_QUERY, 0, 0, 2));
        send_request(make_request(OP_QUERY, 0, 0, 127));

        for (int p = 0; p < PHASES; p++)
        begin
            drain_responses();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_tile_size(phase_tw[p], phase_th[p]);
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            // With the receiver held off, the block backs up and stalls new requests.
            if (p % 4 == 0)
            begin
                holds_asked <= holds_asked + 1;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(0, 99);
                kind = (roll < 30) ? BURST_FILL : (roll < 65) ? BURST_MIXED :
                       (roll < 90) ? BURST_AGE : BURST_NOISE;
                len  = (kind == BURST_FILL) ? $urandom_range(40, 150) : $urandom_range(5, 40);
                for (int n = 0; n < len && sent < ITEMS_PER_PHASE; n++)
                begin
                    send_request(pick_request(kind));
                    sent++;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    drain_responses();
                end
            end
        end

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && rsp_owed == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/tssp_pkg.sv
rtl/core/timed_sprite_slot_pool_unit.sv
tb/tssp_pool_checker.sv
tb/testbench.sv
